FILE: rtl/char_lcd_nibble_writer_unit_assert.svh
// Assertion macros used by the job queue of the character LCD nibble writer RTL.
`ifndef CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH

// The condition must imply the consequence in the same cycle.
`define CLNW_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clnw: same-cycle check failed");

// The condition must imply the consequence in the next cycle.
`define CLNW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clnw: next-cycle check failed");

// The expression must never hold.
`define CLNW_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("clnw: forbidden condition seen");

`endif

FILE: rtl/clnw_pkg.sv
// Types, codes and helper functions of the character LCD nibble writer.
package clnw_pkg;

  // Default geometry and queue size.
  localparam int DEF_ROW_CHARS   = 20;
  localparam int DEF_ROWS        = 4;
  localparam int DEF_QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_US  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_US = 2'd1;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  RST_PULSE_US  = 8'd2;
  localparam logic [15:0] RST_SETTLE_US = 16'd1000;

  // Controller command codes.
  localparam logic [7:0] CMD_CLR   = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CMD_ENTRY = 8'h06;
  localparam logic [7:0] CMD_ON    = 8'h0C;
  localparam logic [7:0] CMD_FUNC4 = 8'h28;
  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] ODD_ROW_BASE = 8'h40;

  // Control characters.
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Power-up timing in microseconds.
  localparam logic [15:0] PWR_WAIT_FIRST = 16'd30000;
  localparam logic [15:0] DLY_15MS       = 16'd15000;
  localparam logic [15:0] DLY_5MS        = 16'd5000;

  // Last step index of the two job kinds and the first power-up byte step.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd1;
  localparam logic [STEP_W-1:0] POWER_LAST_STEP = 4'd11;
  localparam logic [STEP_W-1:0] POWER_BYTE_BASE = 4'd2;

  typedef enum logic [1:0] {
    REQ_CHAR  = 2'd0,
    REQ_GOTO  = 2'd1,
    REQ_CMD   = 2'd2,
    REQ_POWER = 2'd3
  } req_type_e;

  typedef enum logic {
    JOB_BYTE  = 1'b0,
    JOB_POWER = 1'b1
  } job_kind_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [15:0] wait_after_us;
    logic        last;
  } pulse_t;

  // One queued job: a single byte write or the whole power-up run.
  typedef struct packed {
    job_kind_e  kind;
    logic       rs;
    logic [7:0] data;
    logic       dbl_settle;
  } job_t;

  typedef struct packed {
    logic [7:0]  pulse_us;
    logic [15:0] settle_us;
  } cfg_t;

  // Sum of two wait values, clipped at the largest 16-bit count.
  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Command byte of each power-up byte write.
  function automatic logic [7:0] pwr_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0, 3'd1: b = CMD_FUNC4;
      3'd2:       b = CMD_ENTRY;
      3'd3:       b = CMD_ON;
      default:    b = CMD_CLR;
    endcase
    return b;
  endfunction

  // Extra settle time after each power-up byte write.
  function automatic logic [15:0] pwr_extra(input logic [2:0] idx);
    logic [15:0] e;
    unique case (idx)
      3'd0, 3'd1: e = DLY_5MS;
      default:    e = DLY_15MS;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/clnw_stream_if.sv
// Valid/ready stream interface carrying one payload type.
interface clnw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/char_lcd_nibble_writer_unit.sv
// Top level of the character LCD nibble writer: config registers and the three stages.
//
//   channel   direction  payload                                         transfer
//   req_i     in         req_type, value                                 valid & ready
//   pulse_o   out        reg_select, nibble, wait_before_us,             valid & ready
//                        wait_after_us, last
//   cfg       in         cfg_index_i, cfg_data_i                         cfg_we_i
//
// Each accepted request is classified in its cycle and queued; the sequencer puts
// out one pulse per cycle unless the output stalls. The sequencer, stepping once
// per output transfer, sets the sustained rate. A stalled output holds its register;
// the queue keeps accepting until it is full.
// Reset clears the queue, the sequencer and the registers to 2 us and 1000 us.
module char_lcd_nibble_writer_unit #(
  parameter int ROW_CHARS   = clnw_pkg::DEF_ROW_CHARS,
  parameter int ROWS        = clnw_pkg::DEF_ROWS,
  parameter int QUEUE_DEPTH = clnw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [clnw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [clnw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  clnw_stream_if.sink                       req_i,
  clnw_stream_if.source                     pulse_o
);
  import clnw_pkg::*;

  cfg_t cfg_q;
  logic push;
  logic pop;
  logic full;
  logic job_valid;
  job_t push_job;
  job_t head_job;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_us  <= RST_PULSE_US;
      cfg_q.settle_us <= RST_SETTLE_US;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PULSE_US) begin
        cfg_q.pulse_us <= cfg_data_i[7:0];
      end else if (cfg_index_i == CFG_SETTLE_US) begin
        cfg_q.settle_us <= cfg_data_i;
      end
    end
  end

  clnw_front #(
    .ROW_CHARS (ROW_CHARS),
    .ROWS      (ROWS)
  ) u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  clnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (full),
    .valid_o (job_valid)
  );

  clnw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .pulse_o     (pulse_o)
  );

endmodule

FILE: rtl/clnw_front.sv
// Request classifier: maps each request to a queued byte or power-up job.
module clnw_front #(
  parameter int ROW_CHARS = 20,
  parameter int ROWS      = 4
) (
  clnw_stream_if.sink    req_i,
  input  logic           full_i,
  output logic           push_o,
  output clnw_pkg::job_t job_o
);
  import clnw_pkg::*;

  localparam int LIN_W = 9;
  localparam logic [LIN_W-1:0] LIN_LIMIT = LIN_W'(ROWS * ROW_CHARS);

  logic [LIN_W-1:0] lin;
  logic [1:0]       row;
  logic [LIN_W-1:0] col;
  logic [LIN_W-1:0] addr;
  logic             keep;

  assign lin = {1'b0, req_i.data.value};

  // Row by comparison against each row start, column as the remainder.
  always_comb begin
    row = 2'd0;
    for (int k = 1; k < ROWS; k++) begin
      if (lin >= LIN_W'(k * ROW_CHARS)) begin
        row = 2'(k);
      end
    end
    col  = lin - LIN_W'(32'(row) * ROW_CHARS);
    addr = (row[0] ? {1'b0, ODD_ROW_BASE} : '0)
         + (row[1] ? LIN_W'(ROW_CHARS) : '0) + col;
  end

  // Classify the request into a job.
  always_comb begin
    keep            = 1'b1;
    job_o.kind      = JOB_BYTE;
    job_o.rs        = 1'b0;
    job_o.data      = req_i.data.value;
    job_o.dbl_settle = 1'b0;
    unique case (req_type_e'(req_i.data.req_type))
      REQ_CHAR: begin
        if (req_i.data.value == CH_NL || req_i.data.value == CH_FF) begin
          job_o.data = CMD_CLR;
        end else if (req_i.data.value == CH_CR) begin
          job_o.data = CMD_HOME;
        end else begin
          job_o.rs = 1'b1;
        end
      end
      REQ_GOTO: begin
        keep             = lin < LIN_LIMIT;
        job_o.data       = CMD_DDRAM | {1'b0, addr[6:0]};
        job_o.dbl_settle = 1'b1;
      end
      REQ_CMD: begin
        job_o.data = req_i.data.value;
      end
      REQ_POWER: begin
        job_o.kind = JOB_POWER;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // A request is taken whenever the queue has room; out-of-range positions vanish.
  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i && keep;

endmodule

FILE: rtl/clnw_queue.sv
// Short job queue between the classifier and the pulse sequencer.
`include "char_lcd_nibble_writer_unit_assert.svh"

module clnw_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clnw_pkg::job_t job_i,
  input  logic           pop_i,
  output clnw_pkg::job_t job_o,
  output logic           full_o,
  output logic           valid_o
);
  import clnw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_FULL;
  assign valid_o = count_q != '0;
  assign job_o   = slot_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  `CLNW_ASSERT_IMPLIES(a_no_overflow, push_i, !full_o)
  `CLNW_ASSERT_IMPLIES(a_no_underflow, pop_i, valid_o)
  `CLNW_ASSERT_NEXT(a_count_tracks, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

FILE: rtl/clnw_back.sv
// Pulse sequencer: expands each job into enable pulses behind an output register.
module clnw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  clnw_pkg::cfg_t   cfg_i,
  input  logic             job_valid_i,
  input  clnw_pkg::job_t   job_i,
  output logic             pop_o,
  clnw_stream_if.source    pulse_o
);
  import clnw_pkg::*;

  logic                busy_q, busy_d;
  job_t                job_q;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  pulse_t              out_q;
  pulse_t              pulse;
  logic                advance;
  logic                last_step;
  logic [STEP_W-1:0]   pwr_t;
  logic [2:0]          pwr_idx;
  logic [7:0]          cur_byte;
  logic [15:0]         extra;
  logic                low_half;
  logic [15:0]         pulse_w;

  assign pulse_w = {8'd0, cfg_i.pulse_us};
  assign pwr_t   = step_q - POWER_BYTE_BASE;
  assign pwr_idx = pwr_t[3:1];

  // Byte, half and extra settle time of the current step.
  always_comb begin
    if (job_q.kind == JOB_POWER) begin
      cur_byte  = pwr_byte(pwr_idx);
      extra     = pwr_extra(pwr_idx);
      low_half  = pwr_t[0];
      last_step = step_q == POWER_LAST_STEP;
    end else begin
      cur_byte  = job_q.data;
      extra     = job_q.dbl_settle ? cfg_i.settle_us : '0;
      low_half  = step_q[0];
      last_step = step_q == BYTE_LAST_STEP;
    end
  end

  // Pulse fields of the current step.
  always_comb begin
    pulse.reg_select = (job_q.kind == JOB_BYTE) && job_q.rs;
    pulse.last       = last_step;
    if (job_q.kind == JOB_POWER && step_q < POWER_BYTE_BASE) begin
      // Two writes of the high nibble of the 4-bit function set open the power-up run.
      pulse.nibble         = CMD_FUNC4[7:4];
      pulse.wait_before_us = (step_q == '0) ? sat16(PWR_WAIT_FIRST, pulse_w) : pulse_w;
      pulse.wait_after_us  = DLY_15MS;
    end else if (low_half) begin
      pulse.nibble         = cur_byte[3:0];
      pulse.wait_before_us = '0;
      pulse.wait_after_us  = sat16(cfg_i.settle_us, extra);
    end else begin
      pulse.nibble         = cur_byte[7:4];
      pulse.wait_before_us = pulse.reg_select ? '0 : pulse_w;
      pulse.wait_after_us  = pulse_w;
    end
  end

  // Step when the output register is free or being drained.
  assign advance = busy_q && (!out_valid_q || pulse_o.ready);
  assign pop_o   = job_valid_i && (!busy_q || (advance && last_step));

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (pulse_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      step_d      = step_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job and output payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (advance) begin
      out_q <= pulse;
    end
  end

  assign pulse_o.valid = out_valid_q;
  assign pulse_o.data  = out_q;

endmodule
